// ===== hdl/rms_current_meter_with_run_detect_core_defines.svh =====
// ----------------------------------------------------------------------------
// RMS current meter assertion macros
// Assertion wrappers for the RMS current meter, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef RMS_CURRENT_METER_WITH_RUN_DETECT_CORE_DEFINES_SVH
`define RMS_CURRENT_METER_WITH_RUN_DETECT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define RMSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define RMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RMSC_ASSERT(lbl, prop, msg)
`define RMSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/rmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// RMS current meter package
// Widths, reset values, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rmsc_pkg;

    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam int SUM_W    = 64;
    localparam int OFS_W    = 28;
    localparam int ALU_W    = 35;
    localparam int PROD_W   = 56;
    localparam int ROOT_W   = 32;
    localparam int ITER_W   = 6;

    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(SUM_W - 1);
    localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SUM_W / 2 - 1);

    localparam logic [OFS_W-1:0] OFFSET_RESET = 28'd108134400;

    localparam logic [23:0] CAL_RESET   = 24'd1966080;
    localparam logic [15:0] NOISE_RESET = 16'd100;
    localparam logic [15:0] ON_RESET    = 16'd500;
    localparam logic [15:0] OFF_RESET   = 16'd300;

    localparam logic [3:0] REG_CAL   = 4'd0;
    localparam logic [3:0] REG_NOISE = 4'd1;
    localparam logic [3:0] REG_ON    = 4'd2;
    localparam logic [3:0] REG_OFF   = 4'd3;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLOSE  = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_OFS  = 9'b000000010,
        ST_FILT = 9'b000000100,
        ST_SQ   = 9'b000001000,
        ST_ACC  = 9'b000010000,
        ST_DIV  = 9'b000100000,
        ST_SQRT = 9'b001000000,
        ST_MUL  = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/rms_current_meter_with_run_detect_core.sv =====
// ----------------------------------------------------------------------------
// RMS current meter with run detection
// Offset-tracked sample accumulation, windowed RMS, calibration and hysteresis.
// ----------------------------------------------------------------------------
// A sample word runs offset update, filter, square and accumulate in turn.
// A close word runs 64 restoring divide steps and 32 square root
// steps on one shared 35-bit subtractor, then one multiply on the shared
// 32x24 multiplier and a final saturate/hysteresis step; an empty window
// skips to that step. The input is not ready while a word is in progress.
// A finished result sits in an output register; samples keep flowing while it
// waits, a following close waits for it to be taken.
`default_nettype none

`include "rms_current_meter_with_run_detect_core_defines.svh"

module rms_current_meter_with_run_detect_core
    import rmsc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // [11:0] sample_mv
    input  wire logic        s_tuser,     // [0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,     // [15:0] current_ma, [16] running,
                                          // [48:17] run_count
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_addr,
    input  wire logic [23:0] cfg_wr_data
);

    state_t                  state_reg, state_next;
    logic [23:0]             cal_reg, cal_next;
    logic [15:0]             noise_reg, noise_next;
    logic [15:0]             on_reg, on_next;
    logic [15:0]             off_reg, off_next;
    logic [OFS_W-1:0]        offset_reg, offset_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    run_flag_reg, run_flag_next;
    logic [31:0]             run_cnt_reg, run_cnt_next;
    logic [11:0]             samp_reg, samp_next;
    logic [16:0]             fabs_reg, fabs_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [SUM_W-1:0]        work_reg, work_next;
    logic [ALU_W-1:0]        rem_reg, rem_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic [15:0]             cur_reg, cur_next;
    logic                    m_valid_reg, m_valid_next;

    logic                    in_acc;
    logic [OFS_W-1:0]        s_q16;
    logic signed [OFS_W:0]   diff_s;
    logic signed [OFS_W:0]   diff_sh;
    logic [16:0]             f_val;
    logic [ALU_W-1:0]        sub_a, sub_b;
    logic [ALU_W:0]          sub_d;
    logic                    borrow;
    logic [ROOT_W-1:0]       mul_a;
    logic [23:0]             mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [15:0]             cur_sat, cur_fl;
    logic                    out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, run_cnt_reg, run_flag_reg, cur_reg};
    assign out_free = !m_valid_reg || m_tready;

    // offset-free sample, Q12.16 signed
    assign s_q16   = {samp_reg, 16'd0};
    assign diff_s  = $signed({1'b0, s_q16}) - $signed({1'b0, offset_reg});
    assign diff_sh = diff_s >>> 10;
    assign f_val   = diff_s[OFS_W:12];

    // shared subtractor: divide and square root steps
    always_comb begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            ST_DIV: begin
                sub_a = {{(ALU_W-COUNT_BITS-1){1'b0}}, rem_reg[COUNT_BITS-1:0],
                         work_reg[SUM_W-1]};
                sub_b = {{(ALU_W-COUNT_BITS){1'b0}}, count_reg};
            end
            ST_SQRT: begin
                sub_a = {rem_reg[ALU_W-3:0], work_reg[SUM_W-1:SUM_W-2]};
                sub_b = {1'b0, root_reg, 2'b01};
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end
    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = sub_d[ALU_W];

    // shared multiplier: sample square and calibration scale
    always_comb begin
        if (state_reg == ST_SQ) begin
            mul_a = {15'd0, fabs_reg};
            mul_b = {7'd0, fabs_reg};
        end else begin
            mul_a = root_reg;
            mul_b = cal_reg;
        end
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign cur_sat = (|prod_reg[PROD_W-1:36]) ? 16'hFFFF : prod_reg[35:20];
    assign cur_fl  = (cur_sat < noise_reg) ? 16'd0 : cur_sat;

    always_comb begin
        state_next    = state_reg;
        cal_next      = cal_reg;
        noise_next    = noise_reg;
        on_next       = on_reg;
        off_next      = off_reg;
        offset_next   = offset_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        run_flag_next = run_flag_reg;
        run_cnt_next  = run_cnt_reg;
        samp_next     = samp_reg;
        fabs_next     = fabs_reg;
        prod_next     = prod_reg;
        work_next     = work_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        iter_next     = iter_reg;
        cur_next      = cur_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CAL:   cal_next   = cfg_wr_data;
                REG_NOISE: noise_next = cfg_wr_data[15:0];
                REG_ON:    on_next    = cfg_wr_data[15:0];
                REG_OFF:   off_next   = cfg_wr_data[15:0];
                default:   ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    samp_next = s_tdata[11:0];
                    if (s_tuser == FUNC_SAMPLE) begin
                        if (count_reg != COUNT_MAX) begin
                            state_next = ST_OFS;
                        end
                    end else if (count_reg == '0) begin
                        prod_next  = '0;
                        state_next = ST_FIN;
                    end else begin
                        work_next  = sum_reg;
                        rem_next   = '0;
                        iter_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_OFS: begin
                offset_next = offset_reg + diff_sh[OFS_W-1:0];
                state_next  = ST_FILT;
            end
            ST_FILT: begin
                fabs_next  = f_val[16] ? (~f_val + 17'd1) : f_val;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                prod_next  = mul_p;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                sum_next   = sum_reg + SUM_W'(prod_reg);
                count_next = count_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_DIV: begin
                rem_next  = borrow ? sub_a : sub_d[ALU_W-1:0];
                work_next = {work_reg[SUM_W-2:0], ~borrow};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == DIV_LAST) begin
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                rem_next  = borrow ? sub_a : sub_d[ALU_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], ~borrow};
                work_next = {work_reg[SUM_W-3:0], 2'b00};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == SQRT_LAST) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = mul_p;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cur_next     = cur_fl;
                    m_valid_next = 1'b1;
                    sum_next     = '0;
                    count_next   = '0;
                    if (!run_flag_reg && (cur_fl >= on_reg)) begin
                        run_flag_next = 1'b1;
                    end else if (run_flag_reg && (cur_fl < off_reg)) begin
                        run_flag_next = 1'b0;
                        run_cnt_next  = run_cnt_reg + 32'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cal_reg      <= CAL_RESET;
            noise_reg    <= NOISE_RESET;
            on_reg       <= ON_RESET;
            off_reg      <= OFF_RESET;
            offset_reg   <= OFFSET_RESET;
            sum_reg      <= '0;
            count_reg    <= '0;
            run_flag_reg <= 1'b0;
            run_cnt_reg  <= '0;
            iter_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cal_reg      <= cal_next;
            noise_reg    <= noise_next;
            on_reg       <= on_next;
            off_reg      <= off_next;
            offset_reg   <= offset_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            run_flag_reg <= run_flag_next;
            run_cnt_reg  <= run_cnt_next;
            iter_reg     <= iter_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_reg <= samp_next;
        fabs_reg <= fabs_next;
        prod_reg <= prod_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cur_reg  <= cur_next;
    end

    // a sample into a full window leaves the window count and state unchanged
    `RMSC_ASSERT_NEXT(a_full_ignored, in_acc && (s_tuser == FUNC_SAMPLE) && (count_reg == COUNT_MAX), (count_reg == COUNT_MAX) && (state_reg == ST_IDLE), "sample into full window was taken")
    // a new result leaves an empty window behind
    `RMSC_ASSERT(a_window_cleared, $rose(m_valid_reg) |-> (count_reg == '0) && (sum_reg == '0), "window not cleared on close")
    // the run counter moves only on a running-to-stopped transition
    `RMSC_ASSERT(a_run_count_edge, (run_cnt_reg != $past(run_cnt_reg)) |-> ($past(run_flag_reg) && !run_flag_reg), "run count moved without stop")

endmodule

`default_nettype wire
